// File: hw/rtl/vic_pkg.sv
// Shared types and constants for the vertex index compaction block.
`default_nettype none

package vic_pkg;

    localparam int CMD_W  = 2;
    localparam int IDX_W  = 10;
    localparam int KEPT_W = 11;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_MARK  = 2'd1,
        CMD_BUILD = 2'd2,
        CMD_XLATE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_BUILD,
        ST_XLATE
    } t_state;

    typedef struct packed {
        logic accept;
        logic cnt_zero;
        logic sweep;
        logic walk_issue;
        logic mark_set;
        logic imm_load;
        logic imm_oor;
        logic xlate_load;
        logic build_done;
    } t_ctrl;

    typedef struct packed {
        logic in_range;
        logic walk_more;
        logic pend;
        logic sweep_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// File: hw/rtl/vic_ctrl.sv
// Controller state machine that sequences clear sweeps, table builds and lookups.
`default_nettype none

module vic_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic [vic_pkg::CMD_W-1:0]   i_cmd,
    input  wire vic_pkg::t_stat              i_stat,
    output logic                             o_in_ready,
    output vic_pkg::t_ctrl                   o_ctrl
);
    import vic_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;
    logic   accept;

    assign cmd        = t_cmd'(i_cmd);
    assign o_in_ready = (r_state == ST_IDLE) && i_stat.out_free;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (i_stat.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (cmd)
                        CMD_CLEAR: n_state = ST_CLEAR;
                        CMD_MARK:  n_state = ST_IDLE;
                        CMD_BUILD: n_state = ST_BUILD;
                        CMD_XLATE: n_state = i_stat.in_range ? ST_XLATE : ST_IDLE;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (i_stat.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_BUILD: begin
                if (!i_stat.walk_more && !i_stat.pend) begin
                    n_state = ST_IDLE;
                end
            end
            ST_XLATE: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl        = '0;
        o_ctrl.accept = accept;
        unique case (r_state)
            ST_INIT: begin
                o_ctrl.sweep = 1'b1;
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (cmd)
                        CMD_CLEAR: o_ctrl.cnt_zero = 1'b1;
                        CMD_MARK: begin
                            o_ctrl.mark_set = i_stat.in_range;
                            o_ctrl.imm_load = 1'b1;
                            o_ctrl.imm_oor  = !i_stat.in_range;
                        end
                        CMD_BUILD: o_ctrl.cnt_zero = 1'b1;
                        CMD_XLATE: begin
                            o_ctrl.imm_load = !i_stat.in_range;
                            o_ctrl.imm_oor  = !i_stat.in_range;
                        end
                        default: o_ctrl.imm_load = 1'b0;
                    endcase
                end
            end
            ST_CLEAR: begin
                o_ctrl.sweep    = 1'b1;
                o_ctrl.imm_load = i_stat.sweep_last;
            end
            ST_BUILD: begin
                o_ctrl.walk_issue = i_stat.walk_more;
                o_ctrl.build_done = !i_stat.walk_more && !i_stat.pend;
            end
            ST_XLATE: begin
                o_ctrl.xlate_load = 1'b1;
            end
            default: o_ctrl.accept = accept;
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/vic_dpath.sv
// Datapath with the use mark and remap memories, counters and the result register.
`default_nettype none

module vic_dpath #(
    parameter int MAX_VERTICES = 1024
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire vic_pkg::t_ctrl               i_ctrl,
    input  wire logic                         i_cfg_we,
    input  wire logic [vic_pkg::KEPT_W-1:0]   i_cfg_vertex_total,
    input  wire logic [vic_pkg::IDX_W-1:0]    i_index,
    input  wire logic                         i_out_ready,
    output vic_pkg::t_stat                    o_stat,
    output logic                              o_out_valid,
    output logic [vic_pkg::IDX_W-1:0]         o_dense_idx,
    output logic                              o_was_used,
    output logic [vic_pkg::KEPT_W-1:0]        o_kept_count,
    output logic                              o_out_of_range
);
    import vic_pkg::*;

    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int CW     = $clog2(MAX_VERTICES + 1);
    localparam int LIM_W  = (CW > KEPT_W) ? CW : KEPT_W;
    localparam logic [LIM_W-1:0] MAX_L  = LIM_W'(MAX_VERTICES);
    localparam logic [LIM_W-1:0] LAST_L = LIM_W'(MAX_VERTICES - 1);

    logic                 r_marks [MAX_VERTICES];
    logic [IDX_W-1:0]     r_remap [MAX_VERTICES];

    logic [KEPT_W-1:0]    r_vtotal;
    logic [KEPT_W-1:0]    r_kept;
    logic [KEPT_W-1:0]    r_next;
    logic [LIM_W-1:0]     r_cnt;
    logic                 r_pend;
    logic [ADDR_W-1:0]    r_walk_addr;
    logic                 r_mark_q;
    logic [IDX_W-1:0]     r_remap_q;
    logic                 r_out_valid;

    logic [LIM_W-1:0]     vt_ext;
    logic [LIM_W-1:0]     lim;
    logic [LIM_W-1:0]     idx_ext;
    logic [ADDR_W-1:0]    idx_addr;
    logic [ADDR_W-1:0]    cnt_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 mark_we;
    logic [ADDR_W-1:0]    mark_waddr;
    logic                 mark_wdata;
    logic                 load;

    assign vt_ext   = LIM_W'(r_vtotal);
    assign lim      = (vt_ext > MAX_L) ? MAX_L : vt_ext;
    assign idx_ext  = LIM_W'(i_index);
    assign idx_addr = idx_ext[ADDR_W-1:0];
    assign cnt_addr = r_cnt[ADDR_W-1:0];
    assign rd_addr  = i_ctrl.walk_issue ? cnt_addr : idx_addr;

    assign o_stat.in_range   = idx_ext < lim;
    assign o_stat.walk_more  = r_cnt < lim;
    assign o_stat.pend       = r_pend;
    assign o_stat.sweep_last = r_cnt == LAST_L;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign mark_we    = i_ctrl.sweep || i_ctrl.mark_set;
    assign mark_waddr = i_ctrl.sweep ? cnt_addr : idx_addr;
    assign mark_wdata = !i_ctrl.sweep;
    assign load       = i_ctrl.imm_load || i_ctrl.xlate_load || i_ctrl.build_done;

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            r_marks[mark_waddr] <= mark_wdata;
        end
        r_mark_q <= r_marks[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_remap[r_walk_addr] <= r_mark_q ? r_next[IDX_W-1:0] : '0;
        end
        r_remap_q <= r_remap[idx_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtotal    <= '0;
            r_kept      <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vtotal <= i_cfg_vertex_total;
            end
            if (i_ctrl.cnt_zero) begin
                r_cnt <= '0;
            end else if (i_ctrl.sweep) begin
                r_cnt <= o_stat.sweep_last ? '0 : r_cnt + 1'b1;
            end else if (i_ctrl.walk_issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_pend <= i_ctrl.walk_issue;
            if (i_ctrl.build_done) begin
                r_kept <= r_next;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk_addr <= cnt_addr;
        if (i_ctrl.cnt_zero) begin
            r_next <= '0;
        end else if (r_pend && r_mark_q && (r_next != {KEPT_W{1'b1}})) begin
            r_next <= r_next + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_dense_idx    <= i_ctrl.xlate_load ? r_remap_q : '0;
            o_was_used     <= i_ctrl.xlate_load && r_mark_q;
            o_kept_count   <= i_ctrl.build_done ? r_next : r_kept;
            o_out_of_range <= i_ctrl.imm_oor;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: hw/rtl/vertex_index_compaction.sv
// Top level of the vertex index compaction block.
`default_nettype none

// Keeps one use mark per original vertex and builds a table that gives every
// used vertex a dense new number. A mark, and an out-of-range index given to
// a translate, are answered straight from the accepting state; an in-range
// lookup passes through a further state because the marks and the table are
// synchronous memories with registered read data. A clear sweeps the mark
// memory one entry a cycle, and a build reads one mark a cycle up to the
// smaller of vertex_total and MAX_VERTICES. After reset the block runs a
// clearing pass over the mark memory and accepts no item until it ends;
// configuration writes are taken at any time. A result waits in an output
// register, and the next item is taken in the cycle that result transfers.
module vertex_index_compaction #(
    parameter int MAX_VERTICES = 1024
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [vic_pkg::KEPT_W-1:0]   i_cfg_vertex_total,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [vic_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic [vic_pkg::IDX_W-1:0]    i_index,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [vic_pkg::IDX_W-1:0]         o_dense_idx,
    output logic                              o_was_used,
    output logic [vic_pkg::KEPT_W-1:0]        o_kept_count,
    output logic                              o_out_of_range
);
    import vic_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    vic_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_ctrl     (ctrl)
    );

    vic_dpath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctrl             (ctrl),
        .i_cfg_we           (i_cfg_valid && o_cfg_ready),
        .i_cfg_vertex_total (i_cfg_vertex_total),
        .i_index            (i_index),
        .i_out_ready        (i_out_ready),
        .o_stat             (stat),
        .o_out_valid        (o_out_valid),
        .o_dense_idx        (o_dense_idx),
        .o_was_used         (o_was_used),
        .o_kept_count       (o_kept_count),
        .o_out_of_range     (o_out_of_range)
    );

    a_xlate_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.xlate_load |-> $past(ctrl.accept))
        else $error("Translate result loaded without a transfer in the previous cycle.");

    a_no_accept_during_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.accept |-> !stat.pend)
        else $error("Input transfer while a build read is still pending.");

    a_mark_oor_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.accept && (i_cmd == CMD_MARK) && !stat.in_range)
        |=> (o_out_valid && o_out_of_range))
        else $error("Out-of-range mark did not report out of range.");

endmodule

`default_nettype wire
